/* hdl/block_rms_level_meter_core_assert.svh */
// ----------------------------------------------------------------------------
// block rms level meter assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef BLOCK_RMS_LEVEL_METER_CORE_ASSERT_SVH
`define BLOCK_RMS_LEVEL_METER_CORE_ASSERT_SVH

`ifndef SYNTH
// plain property, checked at every edge out of reset
`define BRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication into the next cycle
`define BRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BRM_ASSERT(lbl, prop, msg)
`define BRM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/blkrms_pkg.sv */
// ----------------------------------------------------------------------------
// blkrms_pkg
// shared widths, constants and types of the block rms level meter
// ----------------------------------------------------------------------------
package blkrms_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CHAN_W   = 3;
  localparam int CFG_W    = 4;
  localparam int LEVEL_W  = 16;

  // mean square never exceeds 2^30, so the quotient fits in 31 bits
  localparam int QUO_W    = 31;
  localparam int STEP_W   = 5;

  localparam logic [CFG_W-1:0] ACTIVE_RST = 4'd2;

  // first digit weight of the square root, 4^15
  localparam logic [QUO_W-1:0] SQRT_BIT0 = {1'b1, {(QUO_W-1){1'b0}}};

  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

endpackage

/* hdl/blkrms_ram.sv */
// ----------------------------------------------------------------------------
// blkrms_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module blkrms_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 8
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/blkrms_root.sv */
// ----------------------------------------------------------------------------
// blkrms_root
// iterative mean and root: restoring divide then digit-by-digit square root
// ----------------------------------------------------------------------------
module blkrms_root #(
  parameter int SUM_W = 43,
  parameter int CNT_W = 13
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [SUM_W-1:0]                sum_i,
  input  logic [CNT_W-1:0]                cnt_i,
  output blkrms_pkg::root_stat_t          stat_o,
  output logic [blkrms_pkg::LEVEL_W-1:0]  root_o
);

  localparam int QW = blkrms_pkg::QUO_W;

  typedef enum logic [1:0] {
    R_IDLE,
    R_DIV,
    R_SQRT
  } root_state_e;

  root_state_e                      state_q, state_d;
  logic [blkrms_pkg::STEP_W-1:0]    step_q, step_d;
  logic [QW-1:0]                    quo_q, quo_d;
  logic [CNT_W-1:0]                 rem_q, rem_d;
  logic [CNT_W-1:0]                 dvs_q, dvs_d;
  logic [QW-1:0]                    root_q, root_d;
  logic [QW-1:0]                    bit_q, bit_d;
  logic                             done_q, done_d;

  logic [CNT_W:0] trial;
  logic [CNT_W:0] diff;
  logic           ge;
  logic [QW:0]    rb;
  logic           take;

  always_comb begin
    trial = {rem_q, quo_q[QW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
    rb    = {1'b0, root_q} + {1'b0, bit_q};
    take  = {1'b0, quo_q} >= rb;

    state_d = state_q;
    step_d  = step_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    root_d  = root_q;
    bit_d   = bit_q;
    done_d  = 1'b0;

    case (state_q)
      R_IDLE: begin
        if (start_i) begin
          // upper part of the sum is below the divisor, so it seeds the remainder
          quo_d   = sum_i[QW-1:0];
          rem_d   = CNT_W'(sum_i >> QW);
          dvs_d   = cnt_i;
          step_d  = '0;
          state_d = R_DIV;
        end
      end
      R_DIV: begin
        rem_d  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_d  = {quo_q[QW-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == blkrms_pkg::STEP_W'(QW - 1)) begin
          root_d  = '0;
          bit_d   = blkrms_pkg::SQRT_BIT0;
          state_d = R_SQRT;
        end
      end
      R_SQRT: begin
        if (take) begin
          quo_d  = quo_q - rb[QW-1:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          done_d  = 1'b1;
          state_d = R_IDLE;
        end
      end
      default: begin
        state_d = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      step_q  <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      dvs_q   <= '0;
      root_q  <= '0;
      bit_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      quo_q   <= quo_d;
      rem_q   <= rem_d;
      dvs_q   <= dvs_d;
      root_q  <= root_d;
      bit_q   <= bit_d;
      done_q  <= done_d;
    end
  end

  assign stat_o.busy = (state_q != R_IDLE);
  assign stat_o.done = done_q;
  assign root_o      = root_q[blkrms_pkg::LEVEL_W-1:0];

endmodule

/* hdl/block_rms_level_meter_core.sv */
// ----------------------------------------------------------------------------
// block_rms_level_meter_core
// per-channel block rms meter: squares accumulate in a channel memory,
// block end divides by the count and takes the floor square root
//
//   channel | signals                                       | direction
//   --------+-----------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, sample_i, channel_i,  | sink
//           | last_in_block_i                               |
//   out     | out_valid_o, out_stall_i, level_channel_o,    | source
//           | rms_level_o                                   |
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_data_i          | sink
//
// a sample that is not last goes through accept, then read-modify-write
// a block end passes through accept, read, the 31-step divide and the
// 16-step square root of the shared root unit, then the pick-up and the
// posting of the level
// an ignored channel is taken and dropped; reset clears the accumulators at once
// through per-entry valid bits, so no clearing pass follows reset
// a waiting result sits in the output register while the next transaction is
// taken; a second result waits until that register is free
// ----------------------------------------------------------------------------
`include "block_rms_level_meter_core_assert.svh"

module block_rms_level_meter_core #(
  parameter int MAX_CHANNELS = 8,
  parameter int BLOCK_MAX    = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [blkrms_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [blkrms_pkg::CHAN_W-1:0]        channel_i,
  input  logic                                 last_in_block_i,

  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [blkrms_pkg::CHAN_W-1:0]        level_channel_o,
  output logic [blkrms_pkg::LEVEL_W-1:0]       rms_level_o,

  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [blkrms_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int CNT_W = $clog2(BLOCK_MAX + 1);
  localparam int SUM_W = 30 + CNT_W;
  localparam int ENT_W = SUM_W + CNT_W;
  localparam int AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int QW    = blkrms_pkg::QUO_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_CALC,
    S_DONE
  } meter_state_e;

  meter_state_e                       state_q, state_d;
  logic [blkrms_pkg::CFG_W-1:0]       active_q, active_d;
  logic [MAX_CHANNELS-1:0]            valid_q, valid_d;
  logic [AW-1:0]                      addr_q, addr_d;
  logic [blkrms_pkg::CHAN_W-1:0]      ch_q, ch_d;
  logic                               last_q, last_d;
  logic [QW-1:0]                      sq_q, sq_d;
  logic [blkrms_pkg::LEVEL_W-1:0]     res_q, res_d;
  logic                               out_valid_q, out_valid_d;
  logic [blkrms_pkg::CHAN_W-1:0]      lvl_ch_q, lvl_ch_d;
  logic [blkrms_pkg::LEVEL_W-1:0]     rms_q, rms_d;

  logic [blkrms_pkg::SAMPLE_W-1:0]    mag;
  logic [2*blkrms_pkg::SAMPLE_W-1:0]  prod;
  logic                               metered;
  logic                               in_acc;
  logic                               ram_re;
  logic                               ram_we;
  logic [ENT_W-1:0]                   ram_rdata;
  logic [SUM_W-1:0]                   old_sum, new_sum;
  logic [CNT_W-1:0]                   old_cnt, new_cnt;
  logic                               room;
  logic                               root_start;
  blkrms_pkg::root_stat_t             root_stat;
  logic [blkrms_pkg::LEVEL_W-1:0]     root_val;

  assign mag  = sample_i[blkrms_pkg::SAMPLE_W-1] ? $unsigned(-sample_i) : $unsigned(sample_i);
  assign prod = mag * mag;

  assign metered = ({1'b0, channel_i} < active_q) && (32'(channel_i) < MAX_CHANNELS);
  assign in_acc  = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    // entries never written since reset or since their block end read as zero
    old_sum = valid_q[addr_q] ? ram_rdata[ENT_W-1:CNT_W] : '0;
    old_cnt = valid_q[addr_q] ? ram_rdata[CNT_W-1:0] : '0;
    room    = old_cnt < CNT_W'(BLOCK_MAX);
    new_sum = room ? (old_sum + SUM_W'(sq_q)) : old_sum;
    new_cnt = room ? (old_cnt + 1'b1) : old_cnt;
  end

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    valid_d     = valid_q;
    addr_d      = addr_q;
    ch_d        = ch_q;
    last_d      = last_q;
    sq_d        = sq_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    lvl_ch_d    = lvl_ch_q;
    rms_d       = rms_q;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    root_start  = 1'b0;

    if (cfg_valid_i) begin
      active_d = cfg_data_i;
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc && metered) begin
          ram_re  = 1'b1;
          addr_d  = AW'(channel_i);
          ch_d    = channel_i;
          last_d  = last_in_block_i;
          sq_d    = prod[QW-1:0];
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (last_q) begin
          valid_d[addr_q] = 1'b0;
          if (new_cnt == '0) begin
            res_d   = '0;
            state_d = S_DONE;
          end else begin
            root_start = 1'b1;
            state_d    = S_CALC;
          end
        end else begin
          ram_we          = 1'b1;
          valid_d[addr_q] = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_CALC: begin
        if (root_stat.done) begin
          res_d   = root_val;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          lvl_ch_d    = ch_q;
          rms_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= blkrms_pkg::ACTIVE_RST;
      valid_q     <= '0;
      addr_q      <= '0;
      ch_q        <= '0;
      last_q      <= 1'b0;
      sq_q        <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      lvl_ch_q    <= '0;
      rms_q       <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      valid_q     <= valid_d;
      addr_q      <= addr_d;
      ch_q        <= ch_d;
      last_q      <= last_d;
      sq_q        <= sq_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      lvl_ch_q    <= lvl_ch_d;
      rms_q       <= rms_d;
    end
  end

  // one entry per channel: sum of squares above, sample count below
  blkrms_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_CHANNELS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i ({new_sum, new_cnt}),
    .re_i    (ram_re),
    .raddr_i (AW'(channel_i)),
    .rdata_o (ram_rdata)
  );

  blkrms_root #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .sum_i   (new_sum),
    .cnt_i   (new_cnt),
    .stat_o  (root_stat),
    .root_o  (root_val)
  );

  // the next transaction is held off while a read-modify-write, a block end root or a level post is in flight
  assign in_stall_o      = (state_q != S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign level_channel_o = lvl_ch_q;
  assign rms_level_o     = rms_q;

  `BRM_ASSERT(a_root_done_in_calc, !root_stat.done || (state_q == S_CALC), "root result outside calc")
  `BRM_ASSERT(a_root_idle_outside, root_stat.busy || !(state_q == S_CALC) || root_stat.done || $past(root_start), "calc state with idle root unit")
  `BRM_ASSERT_NEXT(a_write_marks_valid, (state_q == S_UPD) && !last_q, valid_q[$past(addr_q)] && (state_q == S_IDLE), "accumulator write not marked valid")
  `BRM_ASSERT(a_count_bound, !ram_we || (new_cnt <= CNT_W'(BLOCK_MAX)), "sample count beyond block bound")

endmodule
